[hdl/bmf_pkg.sv]
// Shared types and constants for the box mean filter.
// Holds field widths, configuration register codes, the controller state type
// and the command/status structs. No dependencies.
package bmf_pkg;

	localparam int PIX_W       = 8;
	localparam int ROW_W       = 13;
	localparam int OROW_W      = 12;
	localparam int RAD_W       = 7;
	localparam int SIDE_W      = 8;
	localparam int COLSUM_W    = 16;
	localparam int SUM_W       = 23;
	localparam int CNT_W       = 15;
	localparam int SPAN_W      = 8;
	localparam int QBIT_W      = 3;
	localparam int CFG_W       = 13;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_WIDTH_W = 12;
	localparam int MAX_HEIGHT  = 4096;

	localparam int RST_WIDTH  = 640;
	localparam int RST_HEIGHT = 480;
	localparam int RST_RADIUS = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH   = 2'd0,
		CFG_FRAME_HEIGHT  = 2'd1,
		CFG_WINDOW_RADIUS = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIVIDE,
		ST_DELIVER
	} state_t;

	typedef struct packed {
		logic start;
		logic update;
		logic div_step;
		logic deliver;
	} cmd_t;

	typedef struct packed {
		logic pass_thru;
		logic pt_emit;
		logic has_out;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

[hdl/bmf_if.sv]
// Valid/ready channel interfaces for the box mean filter: input samples and
// filtered results. Depends on bmf_pkg for the field widths.
interface bmf_sample_if;
	logic                       valid;
	logic                       ready;
	logic [bmf_pkg::PIX_W-1:0]  pixel_in;
	logic                       flush;

	modport source (output valid, output pixel_in, output flush, input ready);
	modport sink (input valid, input pixel_in, input flush, output ready);
endinterface

interface bmf_result_if;
	logic                       valid;
	logic                       ready;
	logic [bmf_pkg::PIX_W-1:0]  pixel_out;
	logic                       frame_end;

	modport source (output valid, output pixel_out, output frame_end, input ready);
	modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

[hdl/bmf_ctrl.sv]
// Controller state machine of the box mean filter: sequences one request
// through update, division and delivery as it needs them. Depends on bmf_pkg.
module bmf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bmf_pkg::sts_t sts,
	output bmf_pkg::cmd_t cmd
);
	import bmf_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (sts.pt_emit) begin
						state_nxt = ST_DELIVER;
					end else if (!sts.pass_thru) begin
						state_nxt = ST_UPDATE;
					end
				end
			end
			ST_UPDATE: begin
				state_nxt = sts.has_out ? ST_DIVIDE : ST_IDLE;
			end
			ST_DIVIDE: begin
				if (sts.div_last) begin
					state_nxt = ST_DELIVER;
				end
			end
			ST_DELIVER: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		cmd.start    = (state_q == ST_IDLE) && in_valid;
		cmd.update   = (state_q == ST_UPDATE);
		cmd.div_step = (state_q == ST_DIVIDE);
		cmd.deliver  = (state_q == ST_DELIVER) && sts.out_free;
	end

endmodule

[hdl/bmf_datapath.sv]
// Datapath of the box mean filter: configuration registers, position counters,
// line store, column sum memory, running window sum, bit-serial divider and
// the output register. Depends on bmf_pkg.
module bmf_datapath #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_RADIUS = 75
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bmf_pkg::cmd_t                 cmd,
	output bmf_pkg::sts_t                 sts,
	input  logic [bmf_pkg::PIX_W-1:0]     pixel_in,
	input  logic                          flush,
	input  logic                          cfg_we,
	input  logic [bmf_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [bmf_pkg::CFG_W-1:0]     cfg_data,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [bmf_pkg::PIX_W-1:0]     pixel_out,
	output logic                          frame_end
);
	import bmf_pkg::*;

	localparam int CW        = $clog2(MAX_WIDTH);
	localparam int WW        = $clog2(MAX_WIDTH + 1);
	localparam int XW        = (WW > ROW_W ? WW : ROW_W) + 1;
	localparam int RING_ROWS = 2 * MAX_RADIUS + 1;
	localparam int RING_AW   = $clog2(RING_ROWS);
	localparam int RS_DEPTH  = RING_ROWS * (1 << CW);
	localparam int RS_AW     = $clog2(RS_DEPTH);
	localparam int RST_W_EFF = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
	localparam int RST_R_EFF = (RST_RADIUS > MAX_RADIUS) ? MAX_RADIUS : RST_RADIUS;

	// Configuration, already clamped to the usable range.
	logic [WW-1:0]    w_q;
	logic [ROW_W-1:0] h_q;
	logic [RAD_W-1:0] r_q;

	// Frame position.
	logic [ROW_W-1:0]   in_row_q;
	logic [CW-1:0]      in_col_q;
	logic [RING_AW-1:0] ring_q;
	logic [OROW_W-1:0]  orow_q;
	logic [CW-1:0]      ocol_q;

	logic [SUM_W-1:0] ws_q;
	logic [SUM_W-1:0] acc_q;
	logic [PIX_W-1:0] pix_q;

	logic [PIX_W-1:0]    rs_mem [RS_DEPTH];
	logic [COLSUM_W-1:0] cs_mem [MAX_WIDTH];
	logic [PIX_W-1:0]    rs_rd_s1;
	logic [COLSUM_W-1:0] cs_rd_s1;
	logic [COLSUM_W-1:0] cs_sub_s1;

	logic [SUM_W-1:0]  rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [QBIT_W-1:0] div_cnt_q;
	logic [PIX_W-1:0]  q_q;
	logic              fe_q;

	logic              out_valid_q;
	logic [PIX_W-1:0]  out_pix_q;
	logic              out_fe_q;

	logic [XW-1:0] w_x, h_x, r_x, side_x, inrow_x, incol_x, orow_x, ocol_x, ring_x;
	logic [SIDE_W-1:0] side;
	logic pass_thru, fe, has_out, cfg_hit, row_wrap, col_wrap;
	logic [XW-1:0] lo_r, hi_r, lo_c, hi_c;
	logic [SPAN_W-1:0] span_r, span_c;
	logic [PIX_W-1:0] val, old;
	logic [COLSUM_W-1:0] base, new_col;
	logic [SUM_W-1:0] acc_sum, ws_n, dvs;
	logic [RS_AW-1:0] rs_addr;
	logic [CW-1:0] sub_addr;
	logic [CFG_WIDTH_W-1:0] wd;
	logic [WW-1:0] w_cl;
	logic [ROW_W-1:0] h_cl;
	logic [RAD_W-1:0] r_cl;

	assign side    = {r_q, 1'b1};
	assign w_x     = XW'(w_q);
	assign h_x     = XW'(h_q);
	assign r_x     = XW'(r_q);
	assign side_x  = XW'(side);
	assign inrow_x = XW'(in_row_q);
	assign incol_x = XW'(in_col_q);
	assign orow_x  = XW'(orow_q);
	assign ocol_x  = XW'(ocol_q);
	assign ring_x  = XW'(ring_q);

	assign pass_thru = (r_q == '0) || (side_x > w_x) || (side_x > h_x);
	assign fe        = (orow_x == h_x - 1'b1) && (ocol_x == w_x - 1'b1);
	assign has_out   = (inrow_x > r_x) || ((inrow_x == r_x) && (incol_x >= r_x));
	assign col_wrap  = (incol_x == w_x - 1'b1);
	assign row_wrap  = (ring_x == side_x - 1'b1);

	// Edge-clipped window extent along each axis.
	always_comb begin
		lo_r   = (orow_x >= r_x) ? orow_x - r_x : '0;
		hi_r   = (orow_x + r_x < h_x) ? orow_x + r_x : h_x - 1'b1;
		lo_c   = (ocol_x >= r_x) ? ocol_x - r_x : '0;
		hi_c   = (ocol_x + r_x < w_x) ? ocol_x + r_x : w_x - 1'b1;
		span_r = SPAN_W'(hi_r - lo_r + 1'b1);
		span_c = SPAN_W'(hi_c - lo_c + 1'b1);
	end

	// Rows past the frame bottom enter as zero. A column sum is taken as zero
	// on the first row, so the memory never needs a clearing pass. When the
	// column leaving the window is the one being updated (frame exactly one
	// window wide), the freshly updated sum is the one taken away.
	always_comb begin
		val     = (inrow_x < h_x) ? pix_q : '0;
		old     = (inrow_x >= side_x) ? rs_rd_s1 : '0;
		base    = (in_row_q == '0) ? '0 : cs_rd_s1;
		new_col = base + COLSUM_W'(val) - COLSUM_W'(old);
		acc_sum = acc_q + SUM_W'(new_col);
		if (incol_x == r_x) begin
			ws_n = acc_sum;
		end else begin
			ws_n = ws_q;
			if (incol_x > r_x) begin
				ws_n = ws_n + SUM_W'(new_col);
			end
			if (ocol_x >= r_x + 1'b1) begin
				ws_n = ws_n - SUM_W'((sub_addr == in_col_q) ? new_col : cs_sub_s1);
			end
		end
	end

	assign rs_addr  = RS_AW'({ring_q, in_col_q});
	assign sub_addr = CW'(ocol_x - r_x - 1'b1);
	assign dvs      = SUM_W'(cnt_q) << div_cnt_q;

	always_comb begin
		wd   = cfg_data[CFG_WIDTH_W-1:0];
		w_cl = (wd == '0) ? WW'(1) :
			((XW'(wd) > XW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(wd));
		h_cl = (cfg_data == '0) ? ROW_W'(1) :
			((cfg_data > CFG_W'(MAX_HEIGHT)) ? ROW_W'(MAX_HEIGHT) : cfg_data);
		r_cl = (cfg_data[RAD_W-1:0] > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) :
			cfg_data[RAD_W-1:0];
		cfg_hit = cfg_we && ((cfg_idx == CFG_FRAME_WIDTH) ||
			(cfg_idx == CFG_FRAME_HEIGHT) || (cfg_idx == CFG_WINDOW_RADIUS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WW'(RST_W_EFF);
			h_q <= ROW_W'(RST_HEIGHT);
			r_q <= RAD_W'(RST_R_EFF);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_FRAME_WIDTH:   w_q <= w_cl;
				CFG_FRAME_HEIGHT:  h_q <= h_cl;
				CFG_WINDOW_RADIUS: r_q <= r_cl;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q <= '0;
			in_col_q <= '0;
			ring_q   <= '0;
			orow_q   <= '0;
			ocol_q   <= '0;
			ws_q     <= '0;
			acc_q    <= '0;
		end else if (cfg_hit) begin
			in_row_q <= '0;
			in_col_q <= '0;
			ring_q   <= '0;
			orow_q   <= '0;
			ocol_q   <= '0;
			ws_q     <= '0;
			acc_q    <= '0;
		end else if (cmd.start && pass_thru && !flush) begin
			if (fe) begin
				orow_q <= '0;
				ocol_q <= '0;
			end else if (ocol_x == w_x - 1'b1) begin
				ocol_q <= '0;
				orow_q <= orow_q + 1'b1;
			end else begin
				ocol_q <= ocol_q + 1'b1;
			end
		end else if (cmd.update) begin
			if (has_out && fe) begin
				in_row_q <= '0;
				in_col_q <= '0;
				ring_q   <= '0;
				orow_q   <= '0;
				ocol_q   <= '0;
				ws_q     <= '0;
				acc_q    <= '0;
			end else begin
				if (col_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 1'b1;
					ring_q   <= row_wrap ? '0 : ring_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
				if (has_out) begin
					ws_q <= ws_n;
					if (ocol_x == w_x - 1'b1) begin
						ocol_q <= '0;
						orow_q <= orow_q + 1'b1;
					end else begin
						ocol_q <= ocol_q + 1'b1;
					end
				end
				if (in_col_q == '0) begin
					acc_q <= SUM_W'(new_col);
				end else if (incol_x <= r_x) begin
					acc_q <= acc_sum;
				end
			end
		end
	end

	// Line store and column sums: reads issued on accept, writes on update.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pix_q     <= flush ? '0 : pixel_in;
			rs_rd_s1  <= rs_mem[rs_addr];
			cs_rd_s1  <= cs_mem[in_col_q];
			cs_sub_s1 <= cs_mem[sub_addr];
		end
		if (cmd.update) begin
			rs_mem[rs_addr]   <= val;
			cs_mem[in_col_q] <= new_col;
		end
	end

	// Restoring division, one quotient bit per cycle. The mean never exceeds
	// the pixel range, so eight steps cover the quotient.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			q_q  <= pixel_in;
			fe_q <= fe;
		end else if (cmd.update) begin
			rem_q     <= ws_n;
			cnt_q     <= CNT_W'(span_r * span_c);
			div_cnt_q <= '1;
			fe_q      <= fe;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q - 1'b1;
			if (rem_q >= dvs) begin
				rem_q <= rem_q - dvs;
				q_q   <= {q_q[PIX_W-2:0], 1'b1};
			end else begin
				q_q   <= {q_q[PIX_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.deliver) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.deliver) begin
			out_pix_q <= q_q;
			out_fe_q  <= fe_q;
		end
	end

	assign res_valid = out_valid_q;
	assign pixel_out = out_pix_q;
	assign frame_end = out_fe_q;

	always_comb begin
		sts.pass_thru = pass_thru;
		sts.pt_emit   = pass_thru && !flush;
		sts.has_out   = has_out;
		sts.div_last  = (div_cnt_q == '0);
		sts.out_free  = !out_valid_q || res_ready;
	end

endmodule

[hdl/box_mean_filter_edge_normalized_unit.sv]
// Box mean filter over one 8-bit plane in raster order. Each result is the
// truncated mean of the (2R+1)x(2R+1) window around it, clipped at the frame
// edges; results lag the input by R rows plus R pixels, and flush requests
// after the frame drain the rest (frame_end marks the last one). With R = 0,
// or a window taller or wider than the frame, pixels pass through unchanged
// and flush requests are dropped. Steps: a pass-through pixel is accepted,
// then handed off to the output register, and a dropped flush is only
// accepted; in filter mode a request with no result sees accept and update,
// and one that yields a result sees accept, update, eight steps of the
// one-bit-per-cycle divider and hand-off to the output register. The hand-off
// waits while the output register holds a result that is not being taken.
// The output register lets the next request in while a result waits. No
// clearing pass is needed after reset. Configuration writes restart the frame.
module box_mean_filter_edge_normalized_unit #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_RADIUS = 75
) (
	input  logic                          clk,
	input  logic                          arst_n,
	bmf_sample_if.sink                    sample,
	bmf_result_if.source                  result,
	input  logic                          cfg_we,
	input  logic [bmf_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [bmf_pkg::CFG_W-1:0]     cfg_data
);
	import bmf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bmf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bmf_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_RADIUS (MAX_RADIUS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.pixel_in  (sample.pixel_in),
		.flush     (sample.flush),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.res_valid (result.valid),
		.res_ready (result.ready),
		.pixel_out (result.pixel_out),
		.frame_end (result.frame_end)
	);

`ifndef ASSERT_OFF
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.start, cmd.update, cmd.div_step, cmd.deliver}))
		else $error("more than one datapath command in a cycle");

	a_deliver_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.deliver |-> (!result.valid || result.ready))
		else $error("result overwritten before it was taken");

	a_update_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> !cmd.update && (cmd.div_step || sample.ready))
		else $error("update not followed by division or idle");
`endif

endmodule

[sim/box_mean_filter_edge_normalized_unit_test.sv]
// Self-checking test of the box mean filter: directed frames and random frames,
// with random idling on both channels, checked against a built-in predictor.
// Depends on bmf_pkg, bmf_if and the box_mean_filter_edge_normalized_unit RTL.
module box_mean_filter_edge_normalized_unit_test;
	import bmf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_MAX = 2048;
	localparam int RAD_MAX = 75;
	localparam int RING_SIZE = (2 * RAD_MAX + 1) * LINE_MAX;
	localparam int STALL_LIMIT = 4000;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct {
		logic [PIX_W-1:0] pix;
		logic             fl;
	} pixel_req_t;

	typedef struct {
		logic [PIX_W-1:0] pix;
		logic             fe;
	} mean_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	bmf_sample_if sample ();
	bmf_result_if result ();

	box_mean_filter_edge_normalized_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample.sink),
		.result(result.source),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	pixel_req_t pixel_queue[$];
	mean_t      expected_means[$];
	int errors = 0;
	int items_sent = 0;
	int send_gap = 0;
	int recv_stall = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	bit calm = 1'b0;

	// Predictor state: register mirror, line ring, column and window sums.
	int unsigned reg_w = RST_WIDTH, reg_h = RST_HEIGHT, reg_r = RST_RADIUS;
	logic [PIX_W-1:0] line_ring[RING_SIZE];
	int unsigned col_sum[LINE_MAX];
	int unsigned win_sum, in_row, in_col, out_idx;

	task automatic report_error(input string what);
		$display("ERROR at %0t: %s", $realtime, what);
		errors++;
	endtask

	function automatic void restart_frame();
		foreach (col_sum[i]) col_sum[i] = 0;
		win_sum = 0;
		in_row = 0;
		in_col = 0;
		out_idx = 0;
	endfunction

	function automatic int unsigned clipped_span(int unsigned pos, int unsigned r,
			int unsigned limit);
		int unsigned lo, hi;
		lo = (pos >= r) ? pos - r : 0;
		hi = (pos + r < limit) ? pos + r : limit - 1;
		return hi - lo + 1;
	endfunction

	function automatic void predict_mean(input logic [PIX_W-1:0] pix, input logic fl);
		int unsigned w, h, r, total, side, val, old, slot, c, n, k, orow, ocol, cnt;
		mean_t m;
		w = (reg_w == 0) ? 1 : ((reg_w > LINE_MAX) ? LINE_MAX : reg_w);
		h = (reg_h == 0) ? 1 : ((reg_h > MAX_HEIGHT) ? MAX_HEIGHT : reg_h);
		r = (reg_r > RAD_MAX) ? RAD_MAX : reg_r;
		total = w * h;
		side = 2 * r + 1;
		if (r == 0 || side > w || side > h) begin
			if (fl) return;
			m.pix = pix;
			m.fe = (out_idx + 1 >= total);
			out_idx++;
			if (out_idx >= total) restart_frame();
			expected_means.push_back(m);
			return;
		end
		c = in_col % LINE_MAX;
		slot = (in_row % side) * LINE_MAX + c;
		val = (in_row < h && !fl) ? pix : 0;
		old = (in_row >= side) ? line_ring[slot] : 0;
		line_ring[slot] = val[PIX_W-1:0];
		col_sum[c] = col_sum[c] + val - old;
		n = in_row * w + in_col;
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		if (n < r * w + r) return;
		k = out_idx;
		orow = k / w;
		ocol = k % w;
		if (ocol == 0) begin
			win_sum = 0;
			for (int unsigned j = 0; j <= r && j < w; j++) win_sum += col_sum[j];
		end else begin
			if (ocol + r < w) win_sum += col_sum[ocol + r];
			if (ocol >= r + 1) win_sum -= col_sum[ocol - r - 1];
		end
		cnt = clipped_span(orow, r, h) * clipped_span(ocol, r, w);
		m.pix = PIX_W'(win_sum / cnt);
		m.fe = (k + 1 >= total);
		out_idx++;
		if (out_idx >= total) restart_frame();
		expected_means.push_back(m);
	endfunction

	// Sender: holds a request until it is taken, then offers the next one.
	always @(posedge clk or negedge arst_n) begin
		pixel_req_t req;
		if (!arst_n) begin
			sample.valid <= 1'b0;
			sample.pixel_in <= '0;
			sample.flush <= 1'b0;
		end else if (!sample.valid || sample.ready) begin
			if (send_gap > 0) begin
				send_gap--;
				sample.valid <= 1'b0;
			end else if (pixel_queue.size() > 0 && !calm && $urandom_range(0, 15) == 0) begin
				send_gap = $urandom_range(1, 12) - 1;
				sample.valid <= 1'b0;
			end else if (pixel_queue.size() > 0) begin
				req = pixel_queue.pop_front();
				sample.valid <= 1'b1;
				sample.pixel_in <= req.pix;
				sample.flush <= req.fl;
			end else begin
				sample.valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold requested by the stimulus.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			result.ready <= 1'b0;
		end else if (recv_stall > 0) begin
			recv_stall--;
			result.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 11) == 0) begin
			recv_stall = $urandom_range(1, 12) - 1;
			result.ready <= 1'b0;
		end else begin
			result.ready <= 1'b1;
		end
	end

	// Monitor: predicts on each accepted request, checks each accepted result.
	always @(posedge clk) begin
		mean_t want;
		if (arst_n) begin
			if (sample.valid && sample.ready)
				predict_mean(sample.pixel_in, sample.flush);
			if (result.valid && result.ready) begin
				if (expected_means.size() == 0) begin
					report_error($sformatf("unexpected result pixel_out=%0d frame_end=%0b",
						result.pixel_out, result.frame_end));
				end else begin
					want = expected_means.pop_front();
					if (result.pixel_out !== want.pix)
						report_error($sformatf("pixel_out %0d, expected %0d",
							result.pixel_out, want.pix));
					if (result.frame_end !== want.fe)
						report_error($sformatf("frame_end %0b, expected %0b",
							result.frame_end, want.fe));
				end
			end
			if ((sample.valid && sample.ready) || (result.valid && result.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
				$display("** box_mean_filter_edge_normalized_unit: FAILED **");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_FRAME_WIDTH: reg_w = d[CFG_WIDTH_W-1:0];
			CFG_FRAME_HEIGHT: reg_h = d;
			CFG_WINDOW_RADIUS: reg_r = d[RAD_W-1:0];
			default: return;
		endcase
		restart_frame();
	endtask

	task automatic set_frame(input int unsigned w, input int unsigned h, input int unsigned r);
		write_reg(CFG_FRAME_WIDTH, {1'($urandom_range(0, 1)), CFG_WIDTH_W'(w)});
		write_reg(CFG_FRAME_HEIGHT, CFG_W'(h));
		write_reg(CFG_WINDOW_RADIUS, {6'($urandom), RAD_W'(r)});
	endtask

	task automatic push_req(input int pix, input bit fl);
		pixel_req_t req;
		req.pix = pix[PIX_W-1:0];
		req.fl = fl;
		pixel_queue.push_back(req);
		items_sent++;
	endtask

	// Pushes up to limit requests of one frame: pixels, then drain requests, each marked as a flush at random.
	task automatic push_frame(input int unsigned w, input int unsigned h,
			input int unsigned r, input int limit);
		int n;
		n = w * h;
		if (r != 0 && 2 * r + 1 <= w && 2 * r + 1 <= h) n += r * w + r;
		if (limit < n) n = limit;
		for (int i = 0; i < n; i++)
			push_req($urandom_range(0, 255), $urandom_range(0, 19) == 0 || i >= w * h &&
				$urandom_range(0, 1));
	endtask

	// Waits until every request is taken and every result has come back.
	task automatic settle();
		@(negedge clk);
		while (pixel_queue.size() != 0 || sample.valid || expected_means.size() != 0)
			@(negedge clk);
		repeat (16) @(posedge clk);
	endtask

	initial begin
		int unsigned w, h, r;
		int frame_no;
		sample.valid = 1'b0;
		sample.pixel_in = '0;
		sample.flush = 1'b0;
		result.ready = 1'b0;
		restart_frame();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: a few pixels that are still inside the filter lag.
		push_req(255, 0);
		push_req(0, 0);
		push_req(17, 1);
		settle();

		// Small frame in filter mode with a flush inside the frame and pixels in the drain.
		set_frame(4, 3, 1);
		push_req(255, 0); push_req(0, 0); push_req(255, 0); push_req(0, 0);
		push_req(255, 0); push_req(255, 0); push_req(255, 0); push_req(255, 0);
		push_req(99, 1); push_req(0, 0); push_req(128, 0); push_req(7, 0);
		push_req(200, 0); push_req(0, 1); push_req(9, 0); push_req(0, 1); push_req(0, 1);
		settle();

		// Width below range clamps to one; radius zero passes pixels, flushes dropped.
		set_frame(0, 3, 0);
		push_req(1, 0); push_req(255, 1); push_req(2, 0); push_req(3, 0); push_req(4, 1);
		settle();

		// Registers above range: largest frame and radius, so the few pixels sent
		// stay inside the filter lag.
		write_reg(CFG_FRAME_WIDTH, '1);
		write_reg(CFG_FRAME_HEIGHT, '1);
		write_reg(CFG_WINDOW_RADIUS, '1);
		push_req(255, 0); push_req(0, 0); push_req(5, 1);
		settle();

		// A write to the unused index must not disturb the frame that follows.
		set_frame(5, 5, 2);
		write_reg(CFG_UNUSED, '1);
		push_frame(5, 5, 2, 1000);
		settle();

		frame_no = 0;
		while (items_sent < 1100) begin
			frame_no++;
			calm = items_sent > 850;
			case ($urandom_range(0, 9))
				0: begin
					w = $urandom_range(1, 8);
					h = $urandom_range(1, 6);
					r = 0;
				end
				1: begin
					w = $urandom_range(1, 6);
					h = $urandom_range(1, 6);
					r = $urandom_range(3, 75);
				end
				default: begin
					r = $urandom_range(1, 3);
					w = $urandom_range(2 * r + 1, 12);
					h = $urandom_range(2 * r + 1, 9);
				end
			endcase
			set_frame(w, h, r);
			if (frame_no == 4) begin
				@(negedge clk);
				hold_left = 300;
			end
			if (frame_no == 6) begin
				// Sender pauses mid-frame until all results so far are back.
				push_frame(w, h, r, w * h / 2);
				settle();
				for (int i = w * h / 2; i < w * h; i++) push_req($urandom_range(0, 255), 0);
				if (r != 0 && 2 * r + 1 <= w && 2 * r + 1 <= h)
					for (int i = 0; i < r * w + r; i++) push_req(0, 1);
			end else if ($urandom_range(0, 9) == 0) begin
				push_frame(w, h, r, $urandom_range(1, w * h));
			end else begin
				push_frame(w, h, r, 1 << 20);
			end
			settle();
		end

		settle();
		repeat (20) @(posedge clk);
		if (expected_means.size() != 0)
			report_error($sformatf("%0d results never arrived", expected_means.size()));
		if (errors == 0) begin
			$display("** box_mean_filter_edge_normalized_unit: PASSED **");
		end else begin
			$display("** box_mean_filter_edge_normalized_unit: FAILED **");
		end
		$finish;
	end

endmodule
